// ===== rtl/stencil_dissipation_filter_macros.svh =====
// Assertion macros shared by the stencil dissipation filter RTL
`ifndef STENCIL_DISSIPATION_FILTER_MACROS_SVH
`define STENCIL_DISSIPATION_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdf assertion failed");

// Next-cycle implication, disabled while reset is low
`define SDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdf assertion failed");

`endif

// ===== rtl/sdf_pkg.sv =====
// Package: types, codes and stencil coefficient table for the dissipation filter
package sdf_pkg;

  localparam int COEF_W    = 26;
  localparam int COEF_FRAC = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam int PPS_W     = 12;
  localparam int HALF_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TAB_G     = 5;

  // low-pass has no coefficient set at this half width
  localparam logic [HALF_W-1:0] LP_UNSUP_G = 3'd5;

  typedef enum logic [1:0] {
    KIND_LOWER  = 2'd0,
    KIND_VOLUME = 2'd1,
    KIND_UPPER  = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_KIND = 2'd0,
    CFG_HALF_ORDER  = 2'd1,
    CFG_GAIN        = 2'd2,
    CFG_POINTS      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_ACC,
    ST_ROUND,
    ST_GAIN,
    ST_OUT
  } state_e;

  localparam logic FILT_KO = 1'b0;
  localparam logic FILT_LP = 1'b1;

  // [filter kind][G-1][tap]: tap 0 is the centre, Q24
  localparam logic signed [COEF_W-1:0] COEF_TAB [2][TAB_G][TAB_G+1] = '{
    '{
      '{-26'sd33554432, 26'sd16777216, 26'sd0, 26'sd0, 26'sd0, 26'sd0},
      '{-26'sd6291456, 26'sd4194304, -26'sd1048576, 26'sd0, 26'sd0, 26'sd0},
      '{-26'sd5242880, 26'sd3932160, -26'sd1572864, 26'sd262144, 26'sd0, 26'sd0},
      '{-26'sd4587520, 26'sd3670016, -26'sd1835008, 26'sd524288, -26'sd65536, 26'sd0},
      '{-26'sd4128768, 26'sd3440640, -26'sd1966080, 26'sd737280, -26'sd163840,
        26'sd16384}
    },
    '{
      '{-26'sd12582912, 26'sd6291456, 26'sd0, 26'sd0, 26'sd0, 26'sd0},
      '{-26'sd14043429, 26'sd9362286, -26'sd2340571, 26'sd0, 26'sd0, 26'sd0},
      '{-26'sd18543157, 26'sd13907368, -26'sd5562947, 26'sd927158, 26'sd0, 26'sd0},
      '{-26'sd26638945, 26'sd21311156, -26'sd10655578, 26'sd3044451, -26'sd380556,
        26'sd0},
      '{26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0, 26'sd0}
    }
  };

  function automatic logic signed [COEF_W-1:0] coef_get(logic filt, logic [HALF_W-1:0] g,
                                                         int j);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (g >= 3'd1 && int'(g) <= TAB_G && j >= 0 && j <= TAB_G) begin
      c = COEF_TAB[int'(filt)][int'(g) - 1][j];
    end
    return c;
  endfunction

endpackage

// ===== rtl/sdf_cell.sv =====
// Window cell: holds one sample and passes it to the next cell on a shift
module sdf_cell import sdf_pkg::*; #(
  parameter int SW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic signed [SW-1:0] d_i,
  output logic signed [SW-1:0] q_o
);

  logic signed [SW-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

// ===== rtl/sdf_tap.sv =====
// Stencil tap: folds a symmetric sample pair and scales it by its coefficient
module sdf_tap import sdf_pkg::*; #(
  parameter int SW = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [SW-1:0]         a_i,
  input  logic signed [SW-1:0]         b_i,
  input  logic signed [COEF_W-1:0]     coef_i,
  output logic signed [SW+COEF_W:0]    prod_o
);

  logic signed [SW:0]        pair;
  logic signed [SW+COEF_W:0] prod_d, prod_q;

  assign pair   = (SW+1)'(a_i) + (SW+1)'(b_i);
  assign prod_d = pair * coef_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/stencil_dissipation_filter.sv =====
// An emitting input runs in turn through TAP (tap), ACC (sum), ROUND, GAIN and OUT
// (saturate) on one item before its result is valid. One item every cycle while
// idle and emitting nothing; input stalls until OUT loads an emitting item's result.
// A result held in the output register does not block the next input transaction.
// Reset clears the sample window, stripe counters and control; registers take
// filter_kind 0, half_order 1, gain 0, points_per_stripe 16.
`include "stencil_dissipation_filter_macros.svh"
module stencil_dissipation_filter import sdf_pkg::*; #(
  parameter int MAX_HALF_ORDER = 5,
  parameter int SAMPLE_WIDTH   = 32,
  parameter int MAX_POINTS     = 4095
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     in_kind_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_value_o,
  output logic                           out_last_in_stripe_o,
  output logic                           out_unsupported_o
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int WIN    = 2 * MAX_HALF_ORDER + 1;
  localparam int WIN_IW = $clog2(WIN);
  localparam int NTAP   = MAX_HALF_ORDER + 1;
  localparam int P_W    = SW + COEF_W + 1;
  localparam int ACC_W  = P_W + 3;
  localparam int S_W    = ACC_W - COEF_FRAC;
  localparam int G_W    = S_W + GAIN_W + 1;
  localparam int R_W    = G_W - GAIN_FRAC + 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int UP_W   = $clog2(MAX_HALF_ORDER + 1);

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [G_W-1:0]   G_HALF   = G_W'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [R_W-1:0]   SAT_MAX  = R_W'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [R_W-1:0]   SAT_MIN  = -SAT_MAX - R_W'(1);

  // configuration registers
  logic              filter_kind_q;
  logic [HALF_W-1:0] half_order_q;
  logic [GAIN_W-1:0] gain_q;
  logic [PPS_W-1:0]  points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_kind_q <= FILT_KO;
      half_order_q  <= 3'd1;
      gain_q        <= '0;
      points_q      <= 12'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_KIND: filter_kind_q <= cfg_wdata_i[0];
        CFG_HALF_ORDER:  half_order_q  <= cfg_wdata_i[HALF_W-1:0];
        CFG_GAIN:        gain_q        <= cfg_wdata_i[GAIN_W-1:0];
        CFG_POINTS:      points_q      <= cfg_wdata_i[PPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [HALF_W-1:0] g_eff;
  int                p_eff;

  always_comb begin
    g_eff = half_order_q;
    if (half_order_q == 3'd0) g_eff = 3'd1;
    else if (int'(half_order_q) > MAX_HALF_ORDER) g_eff = HALF_W'(MAX_HALF_ORDER);
    p_eff = (int'(points_q) > MAX_POINTS) ? MAX_POINTS : int'(points_q);
  end

  // control state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  vol_q, vol_d;
  logic [UP_W-1:0]   up_q, up_d;
  logic              last_q, last_d;
  logic              in_acc, shift, emit, out_free;
  logic              tap_en, acc_en, rnd_en, gain_en, out_load;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    shift  = 1'b0;
    emit   = 1'b0;
    vol_d  = vol_q;
    up_d   = up_q;
    last_d = last_q;
    if (in_acc) begin
      unique case (in_kind_i)
        KIND_LOWER: begin
          shift = 1'b1;
          vol_d = '0;
          up_d  = '0;
        end
        KIND_VOLUME: begin
          if (int'(vol_q) < p_eff) begin
            shift  = 1'b1;
            vol_d  = vol_q + CNT_W'(1);
            emit   = (int'(vol_q) + 1) > int'(g_eff);
            last_d = 1'b0;
          end
        end
        KIND_UPPER: begin
          if (int'(vol_q) >= p_eff && int'(up_q) < int'(g_eff)) begin
            shift  = 1'b1;
            up_d   = up_q + UP_W'(1);
            emit   = 1'b1;
            last_d = (int'(up_q) + 1) == int'(g_eff);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vol_q   <= '0;
      up_q    <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vol_q   <= vol_d;
      up_q    <= up_d;
      last_q  <= last_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (emit) state_d = ST_TAP;
      ST_TAP:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_ROUND;
      ST_ROUND: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    tap_en     = 1'b0;
    acc_en     = 1'b0;
    rnd_en     = 1'b0;
    gain_en    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_TAP:   tap_en     = 1'b1;
      ST_ACC:   acc_en     = 1'b1;
      ST_ROUND: rnd_en     = 1'b1;
      ST_GAIN:  gain_en    = 1'b1;
      ST_OUT:   out_load   = out_free;
      default: ;
    endcase
  end

  // sample window: chain of cells, newest at index 0
  logic signed [SW-1:0] win [WIN];

  for (genvar i = 0; i < WIN; i++) begin : g_cell
    logic signed [SW-1:0] d;
    if (i == 0) begin : g_head
      assign d = in_sample_i;
    end else begin : g_link
      assign d = win[i-1];
    end
    sdf_cell #(.SW(SW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .d_i    (d),
      .q_o    (win[i])
    );
  end

  // tap operand selection around the centre at index G
  logic signed [SW-1:0]     tap_a [NTAP];
  logic signed [SW-1:0]     tap_b [NTAP];
  logic signed [COEF_W-1:0] tap_c [NTAP];
  logic signed [P_W-1:0]    tap_p [NTAP];

  always_comb begin
    for (int j = 0; j < NTAP; j++) begin
      int lo, hi;
      lo = int'(g_eff) - j;
      hi = int'(g_eff) + j;
      tap_a[j] = '0;
      tap_b[j] = '0;
      tap_c[j] = '0;
      if (lo >= 0) begin
        tap_a[j] = win[WIN_IW'(lo)];
        if (j != 0) tap_b[j] = win[WIN_IW'(hi)];
        tap_c[j] = coef_get(filter_kind_q, g_eff, j);
      end
    end
  end

  for (genvar j = 0; j < NTAP; j++) begin : g_tap
    sdf_tap #(.SW(SW)) u_tap (
      .clk_i (clk_i),
      .en_i  (tap_en),
      .a_i   (tap_a[j]),
      .b_i   (tap_b[j]),
      .coef_i(tap_c[j]),
      .prod_o(tap_p[j])
    );
  end

  // datapath after the taps
  logic signed [ACC_W-1:0] acc_d, acc_q, acc_rnd;
  logic signed [S_W-1:0]   s_q;
  logic signed [G_W-1:0]   gp_q, gp_rnd;
  logic signed [GAIN_W:0]  gain_s;
  logic signed [R_W-1:0]   r_sum;
  logic signed [SW-1:0]   centre, res_d;
  logic                    unsup;

  always_comb begin
    acc_d = '0;
    for (int j = 0; j < NTAP; j++) begin
      acc_d = acc_d + ACC_W'(tap_p[j]);
    end
  end

  assign acc_rnd = acc_q + ACC_HALF;
  assign gain_s  = signed'({1'b0, gain_q});
  assign gp_rnd  = gp_q + G_HALF;
  assign centre  = win[WIN_IW'(g_eff)];
  assign r_sum   = R_W'(centre) + R_W'(signed'(gp_rnd[G_W-1:GAIN_FRAC]));
  assign unsup   = (filter_kind_q == FILT_LP) && (g_eff == LP_UNSUP_G);

  always_comb begin
    if (unsup) res_d = '0;
    else if (r_sum > SAT_MAX) res_d = SAT_MAX[SW-1:0];
    else if (r_sum < SAT_MIN) res_d = SAT_MIN[SW-1:0];
    else res_d = r_sum[SW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) acc_q <= acc_d;
    if (rnd_en) s_q <= acc_rnd[ACC_W-1:COEF_FRAC];
    if (gain_en) gp_q <= s_q * gain_s;
  end

  // output register
  logic                 out_valid_q;
  logic signed [SW-1:0] out_val_q;
  logic                 out_last_q, out_unsup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q   <= res_d;
      out_last_q  <= last_q;
      out_unsup_q <= unsup;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_filtered_value_o = out_val_q;
  assign out_last_in_stripe_o = out_last_q;
  assign out_unsupported_o    = out_unsup_q;

  `SDF_ASSERT_NEXT(a_emit_starts_tap, clk_i, rst_ni, emit, state_q == ST_TAP)
  `SDF_ASSERT_NEXT(a_out_holds_when_blocked, clk_i, rst_ni,
                   state_q == ST_OUT && !out_free, state_q == ST_OUT && out_valid_q)
  `SDF_ASSERT_NOW(a_unsup_value_zero, clk_i, rst_ni,
                  out_valid_q && out_unsup_q, out_val_q == '0)

endmodule
